[rtl/core/c3f_pkg.sv]
// ----------------------------------------------------------------------------
// c3f_pkg
// Types and constants shared by the 3x3 filter modules.
// ----------------------------------------------------------------------------
package c3f_pkg;

	localparam int QDEPTH = 8;
	localparam int QAW    = 3;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_BELOW  = 3'd2,
		REG_MIDDLE = 3'd3,
		REG_ABOVE  = 3'd4,
		REG_OFFSET = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [47:0] coef_row_below;
		logic [47:0] coef_row_middle;
		logic [47:0] coef_row_above;
		logic [21:0] sum_offset;
	} cfg_t;

	// Up to three results caused by one input pixel. Slot 0 is the interior
	// or left copy at (row-1, col-1), slot 1 the right copy at (row-1, col),
	// slot 2 the top or bottom copy at (row, col).
	typedef struct packed {
		logic [2:0]  slots;
		logic [7:0]  pix0;
		logic [7:0]  pix1;
		logic [7:0]  pix2;
		logic [11:0] row;
		logic [11:0] col;
		logic        fend;
	} bundle_t;

endpackage

[rtl/core/c3f_front.sv]
// ----------------------------------------------------------------------------
// c3f_front
// Counts position, keeps line stores and window, and computes the filter.
// ----------------------------------------------------------------------------
module c3f_front #(
	parameter int MAX_WIDTH      = 4096,
	parameter int MAX_HEIGHT     = 4096,
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  c3f_pkg::cfg_t     cfg,
	input  logic              acc,
	input  logic [7:0]        pixel_in,
	output logic              out_valid,
	output c3f_pkg::bundle_t  out_bundle
);
	import c3f_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int SW = 32;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW:0]   w_eff;
	logic [RW:0]   h_eff;
	logic          wrap;
	logic [CW-1:0] c_cur;
	logic [RW-1:0] r_cur;
	logic [CW:0]   c_inc;
	logic [RW:0]   r_inc;

	logic [7:0] older_mem [MAX_WIDTH];
	logic [7:0] newer_mem [MAX_WIDTH];
	logic [7:0] rd_a_s1, rd_m_s1;

	logic          v_s1, mid_s1, c1_s1, lastc_s1, copy_s1, fend_s1;
	logic [7:0]    pix_s1;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] r_s1;
	logic [7:0]    win_q [6];

	logic              v_s2, mid_s2, c1_s2, lastc_s2, copy_s2, fend_s2;
	logic [7:0]        lcopy_s2, m_s2, b_s2;
	logic [11:0]       r_s2, c_s2;
	logic signed [24:0] prod_s2 [9];

	logic              v_s3, mid_s3, c1_s3, lastc_s3, copy_s3, fend_s3;
	logic [7:0]        lcopy_s3, m_s3, b_s3;
	logic [11:0]       r_s3, c_s3;
	logic signed [SW-1:0] sum_s3;

	logic signed [24:0]   prod [9];
	logic signed [SW-1:0] sum_d;
	logic [7:0]           filt;
	logic signed [SW-1:0] quot;

	function automatic logic signed [24:0] mul_tap(input logic [47:0] packed_taps,
			input int which, input logic [7:0] p);
		logic signed [15:0] t;
		logic signed [8:0]  ps;
		begin
			t  = packed_taps[16*which +: 16];
			ps = $signed({1'b0, p});
			mul_tap = 25'(t * ps);
		end
	endfunction

	always_comb begin
		int wi, hi;
		wi = int'(cfg.image_width);
		hi = int'(cfg.image_height);
		if (wi < 2) wi = 2;
		if (wi > MAX_WIDTH) wi = MAX_WIDTH;
		if (hi < 2) hi = 2;
		if (hi > MAX_HEIGHT) hi = MAX_HEIGHT;
		w_eff = (CW+1)'(wi);
		h_eff = (RW+1)'(hi);
		wrap  = ({1'b0, col_q} >= w_eff) || ({1'b0, row_q} >= h_eff);
		c_cur = wrap ? '0 : col_q;
		r_cur = wrap ? '0 : row_q;
		c_inc = {1'b0, c_cur} + 1'b1;
		r_inc = {1'b0, r_cur} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (c_inc == w_eff) begin
				col_q <= '0;
				row_q <= (r_inc == h_eff) ? '0 : r_inc[RW-1:0];
			end else begin
				col_q <= c_inc[CW-1:0];
				row_q <= r_cur;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_a_s1 <= older_mem[c_cur];
			rd_m_s1 <= newer_mem[c_cur];
		end
		if (v_s1) begin
			older_mem[c_s1] <= rd_m_s1;
			newer_mem[c_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s1) begin
				win_q[3] <= win_q[0];
				win_q[4] <= win_q[1];
				win_q[5] <= win_q[2];
				win_q[0] <= rd_a_s1;
				win_q[1] <= rd_m_s1;
				win_q[2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pix_s1   <= pixel_in;
		c_s1     <= c_cur;
		r_s1     <= r_cur;
		mid_s1   <= (r_cur >= RW'(2)) && (c_cur != '0);
		c1_s1    <= (c_cur == CW'(1));
		lastc_s1 <= (c_inc == w_eff);
		copy_s1  <= (r_cur == '0) || (r_inc == h_eff);
		fend_s1  <= (r_inc == h_eff) && (c_inc == w_eff);
	end

	always_comb begin
		prod[0] = mul_tap(cfg.coef_row_below, 0, win_q[5]);
		prod[1] = mul_tap(cfg.coef_row_below, 1, win_q[2]);
		prod[2] = mul_tap(cfg.coef_row_below, 2, pix_s1);
		prod[3] = mul_tap(cfg.coef_row_middle, 0, win_q[4]);
		prod[4] = mul_tap(cfg.coef_row_middle, 1, win_q[1]);
		prod[5] = mul_tap(cfg.coef_row_middle, 2, rd_m_s1);
		prod[6] = mul_tap(cfg.coef_row_above, 0, win_q[3]);
		prod[7] = mul_tap(cfg.coef_row_above, 1, win_q[0]);
		prod[8] = mul_tap(cfg.coef_row_above, 2, rd_a_s1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) prod_s2[i] <= prod[i];
		mid_s2   <= mid_s1;
		c1_s2    <= c1_s1;
		lastc_s2 <= lastc_s1;
		copy_s2  <= copy_s1;
		fend_s2  <= fend_s1;
		lcopy_s2 <= win_q[1];
		m_s2     <= rd_m_s1;
		b_s2     <= pix_s1;
		r_s2     <= 12'(r_s1);
		c_s2     <= 12'(c_s1);
	end

	always_comb begin
		sum_d = SW'($signed(cfg.sum_offset)) + (SW'(1) <<< (COEF_FRAC_BITS - 1));
		for (int i = 0; i < 9; i++) sum_d = sum_d + SW'(prod_s2[i]);
	end

	always_ff @(posedge clk) begin
		sum_s3   <= sum_d;
		mid_s3   <= mid_s2;
		c1_s3    <= c1_s2;
		lastc_s3 <= lastc_s2;
		copy_s3  <= copy_s2;
		fend_s3  <= fend_s2;
		lcopy_s3 <= lcopy_s2;
		m_s3     <= m_s2;
		b_s3     <= b_s2;
		r_s3     <= r_s2;
		c_s3     <= c_s2;
	end

	always_comb begin
		quot = sum_s3 >>> COEF_FRAC_BITS;
		if (sum_s3 < 0) begin
			filt = 8'd0;
		end else if (quot > SW'(255)) begin
			filt = 8'd255;
		end else begin
			filt = quot[7:0];
		end
		out_valid        = v_s3;
		out_bundle.slots = {copy_s3, mid_s3 && lastc_s3, mid_s3};
		out_bundle.pix0  = c1_s3 ? lcopy_s3 : filt;
		out_bundle.pix1  = m_s3;
		out_bundle.pix2  = b_s3;
		out_bundle.row   = r_s3;
		out_bundle.col   = c_s3;
		out_bundle.fend  = fend_s3;
	end

endmodule

[rtl/core/c3f_fifo.sv]
// ----------------------------------------------------------------------------
// c3f_fifo
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module c3f_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  c3f_pkg::bundle_t wr_data,
	input  logic             rd_en,
	output c3f_pkg::bundle_t rd_data,
	output logic             not_empty
);
	import c3f_pkg::*;

	bundle_t      mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
		end
	end

	assign rd_data   = mem_q[rp_q];
	assign not_empty = (cnt_q != '0);

endmodule

[rtl/core/c3f_back.sv]
// ----------------------------------------------------------------------------
// c3f_back
// Takes bundles from the queue and delivers their results one beat at a time.
// ----------------------------------------------------------------------------
module c3f_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_nempty,
	input  c3f_pkg::bundle_t q_data,
	output logic             q_rd,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       pixel_out,
	output logic [11:0]      out_row,
	output logic [11:0]      out_col,
	output logic             run_end,
	output logic             frame_end
);
	import c3f_pkg::*;

	bundle_t    cur_q;
	logic       cur_v_q;
	logic [2:0] rem_q;
	logic [2:0] sel, rest;
	logic       take;

	always_comb begin
		sel  = rem_q & (~rem_q + 3'd1);
		rest = rem_q & ~sel;
		take = cur_v_q && pop;
		q_rd = q_nempty && (!cur_v_q || (take && rest == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			rem_q   <= '0;
		end else if (q_rd) begin
			cur_v_q <= 1'b1;
			rem_q   <= q_data.slots;
		end else if (take) begin
			rem_q   <= rest;
			cur_v_q <= (rest != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) cur_q <= q_data;
	end

	always_comb begin
		empty     = !cur_v_q;
		run_end   = (rest == '0);
		frame_end = sel[2] && cur_q.fend;
		pixel_out = sel[0] ? cur_q.pix0 : (sel[1] ? cur_q.pix1 : cur_q.pix2);
		out_row   = sel[2] ? cur_q.row : cur_q.row - 12'd1;
		out_col   = sel[0] ? cur_q.col - 12'd1 : cur_q.col;
	end

endmodule

[rtl/core/conv3x3_u8_filter.sv]
// ----------------------------------------------------------------------------
// conv3x3_u8_filter
// Streaming 3x3 convolution of an 8-bit image with edge copy-through.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on push/full; a beat is taken when push is
// high and full is low. Results leave on empty/pop: the oldest result is on
// the ports while empty is low and is taken when pop is high. Each pixel
// causes zero to three results, tagged with row, column, run_end and
// frame_end. Configuration is written on cfg_valid/cfg_ready, which is
// always ready, and should only change while the block is idle.
// The front accepts one pixel per cycle while full is low. A beat passes
// through registers s1, s2 and s3 to its bundle in the result queue, then
// to the output register of the back. The back delivers one result per
// cycle while pop is high, so the sustained rate is one pixel per cycle
// where a pixel causes one result, and is set by the single result port
// elsewhere. full rises when eight bundles are in the pipeline or queue, so a
// stalled receiver stops input after a few beats and nothing is lost. Reset
// clears counters, window, queue and registers to defaults, but not line stores.
// ----------------------------------------------------------------------------
module conv3x3_u8_filter #(
	parameter int MAX_WIDTH      = 4096,
	parameter int MAX_HEIGHT     = 4096,
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  pixel_in,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  pixel_out,
	output logic [11:0] out_row,
	output logic [11:0] out_col,
	output logic        run_end,
	output logic        frame_end
);
	import c3f_pkg::*;

	cfg_t         cfg_q;
	logic         acc;
	logic         f_valid;
	bundle_t      f_bundle;
	logic         q_wr, q_rd, q_nempty, drop;
	bundle_t      q_data;
	logic [QAW:0] busy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= 13'd640;
			cfg_q.image_height    <= 13'd480;
			cfg_q.coef_row_below  <= '0;
			cfg_q.coef_row_middle <= 48'h0000_1000_0000;
			cfg_q.coef_row_above  <= '0;
			cfg_q.sum_offset      <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  cfg_q.image_width     <= cfg_data[12:0];
				REG_HEIGHT: cfg_q.image_height    <= cfg_data[12:0];
				REG_BELOW:  cfg_q.coef_row_below  <= cfg_data;
				REG_MIDDLE: cfg_q.coef_row_middle <= cfg_data;
				REG_ABOVE:  cfg_q.coef_row_above  <= cfg_data;
				REG_OFFSET: cfg_q.sum_offset      <= cfg_data[21:0];
				default: begin
				end
			endcase
		end
	end

	assign full = (busy_q >= (QAW+1)'(QDEPTH));
	assign acc  = push && !full;
	assign q_wr = f_valid && (f_bundle.slots != '0);
	assign drop = f_valid && (f_bundle.slots == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			busy_q <= busy_q + (QAW+1)'(acc) - (QAW+1)'(drop) - (QAW+1)'(q_rd);
		end
	end

	c3f_front #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.acc        (acc),
		.pixel_in   (pixel_in),
		.out_valid  (f_valid),
		.out_bundle (f_bundle)
	);

	c3f_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_wr),
		.wr_data   (f_bundle),
		.rd_en     (q_rd),
		.rd_data   (q_data),
		.not_empty (q_nempty)
	);

	c3f_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nempty  (q_nempty),
		.q_data    (q_data),
		.q_rd      (q_rd),
		.empty     (empty),
		.pop       (pop),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col),
		.run_end   (run_end),
		.frame_end (frame_end)
	);

endmodule

[rtl/core/c3f_checker.sv]
// ----------------------------------------------------------------------------
// c3f_checker
// Port-level checks of the 3x3 filter, bound to the top level.
// ----------------------------------------------------------------------------
module c3f_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        cfg_ready,
	input logic [7:0]  pixel_out,
	input logic [11:0] out_row,
	input logic [11:0] out_col,
	input logic        run_end,
	input logic        frame_end
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("results shown during reset");

	a_fend_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> run_end)
		else $error("frame end beat does not close its run");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pixel_out) && $stable(out_row)
			&& $stable(out_col) && $stable(run_end)))
		else $error("stalled result beat changed");

endmodule

bind conv3x3_u8_filter c3f_checker u_c3f_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.cfg_ready (cfg_ready),
	.pixel_out (pixel_out),
	.out_row   (out_row),
	.out_col   (out_col),
	.run_end   (run_end),
	.frame_end (frame_end)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the streaming 3x3 u8 convolution filter.
// A beat-level predictor of the filter computes the expected results of
// every accepted pixel beat. A receiver process pops results and compares
// them field by field with the oldest expected result. Tests cover edge
// copy-through, tap and offset extremes, rounding ties, clamping, size
// clamping, a mid-frame size change, back pressure and random frames under
// several idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import c3f_pkg::*;

	typedef struct {
		logic [7:0]  pix;
		logic [11:0] row;
		logic [11:0] col;
		logic        re;
		logic        fe;
	} px_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        push;
	logic        full;
	logic [7:0]  pixel_in;
	logic        empty;
	logic        pop;
	logic [7:0]  pixel_out;
	logic [11:0] out_row;
	logic [11:0] out_col;
	logic        run_end;
	logic        frame_end;

	conv3x3_u8_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .pixel_in(pixel_in),
		.empty(empty), .pop(pop),
		.pixel_out(pixel_out), .out_row(out_row), .out_col(out_col),
		.run_end(run_end), .frame_end(frame_end)
	);

	// Filter model state
	logic [12:0] m_width, m_height;
	logic [47:0] m_below, m_middle, m_above;
	logic [21:0] m_offset;
	logic [7:0]  older_mem [4096];
	logic [7:0]  newer_mem [4096];
	logic [7:0]  win [6];
	int unsigned col_cnt, row_cnt;

	px_result_t  expected_q [$];
	int          err_cnt;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;
	longint      cycle_cnt;

	localparam longint CYCLE_LIMIT = 2000000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint tap_of(logic [47:0] p, int k);
		logic signed [15:0] v;
		v = p[16*k +: 16];
		return longint'(v);
	endfunction

	function automatic longint row_dot(logic [47:0] p, logic [7:0] l, logic [7:0] c,
			logic [7:0] r);
		return tap_of(p, 0) * l + tap_of(p, 1) * c + tap_of(p, 2) * r;
	endfunction

	function automatic int unsigned size_of(logic [12:0] v);
		if (v < 2) return 2;
		if (v > 4096) return 4096;
		return v;
	endfunction

	function automatic void add_result(logic [7:0] p, int unsigned r, int unsigned c,
			logic fe);
		px_result_t x;
		x.pix = p;
		x.row = r[11:0];
		x.col = c[11:0];
		x.re  = 1'b0;
		x.fe  = fe;
		expected_q.push_back(x);
	endfunction

	function automatic void predict_pixel(logic [7:0] b);
		int unsigned w, h, r, c;
		logic [7:0] a, m, v;
		logic signed [21:0] off;
		longint s, t;
		int n0;
		w = size_of(m_width);
		h = size_of(m_height);
		n0 = expected_q.size();
		if (col_cnt >= w || row_cnt >= h) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		r = row_cnt;
		c = col_cnt;
		a = older_mem[c];
		m = newer_mem[c];
		if (r >= 2 && c >= 1) begin
			if (c == 1) begin
				add_result(win[1], r - 1, 0, 1'b0);
			end else begin
				off = m_offset;
				s = longint'(off);
				s += row_dot(m_below, win[5], win[2], b);
				s += row_dot(m_middle, win[4], win[1], m);
				s += row_dot(m_above, win[3], win[0], a);
				t = s + 2048;
				if (t < 0) v = 8'd0;
				else if ((t >>> 12) > 255) v = 8'd255;
				else v = t[19:12];
				add_result(v, r - 1, c - 1, 1'b0);
			end
			if (c == w - 1) add_result(m, r - 1, c, 1'b0);
		end
		if (r == 0 || r == h - 1) add_result(b, r, c, (r == h - 1) && (c == w - 1));
		if (expected_q.size() > n0) expected_q[expected_q.size() - 1].re = 1'b1;
		win[3] = win[0];
		win[4] = win[1];
		win[5] = win[2];
		win[0] = a;
		win[1] = m;
		win[2] = b;
		older_mem[c] = m;
		newer_mem[c] = b;
		col_cnt = c + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = r + 1;
			if (row_cnt >= h) row_cnt = 0;
		end
	endfunction

	function automatic void model_config(reg_idx_t idx, logic [47:0] d);
		case (idx)
			REG_WIDTH:  m_width  = d[12:0];
			REG_HEIGHT: m_height = d[12:0];
			REG_BELOW:  m_below  = d;
			REG_MIDDLE: m_middle = d;
			REG_ABOVE:  m_above  = d;
			REG_OFFSET: m_offset = d[21:0];
			default: ;
		endcase
	endfunction

	// Leaves cfg_valid high so back-to-back writes need no lowering.
	task automatic write_reg(reg_idx_t idx, logic [47:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model_config(idx, d);
	endtask

	task automatic set_filter(logic [12:0] w, logic [12:0] h, logic [47:0] below,
			logic [47:0] middle, logic [47:0] above, logic [21:0] off);
		write_reg(REG_WIDTH, 48'(w));
		write_reg(REG_HEIGHT, 48'(h));
		write_reg(REG_BELOW, below);
		write_reg(REG_MIDDLE, middle);
		write_reg(REG_ABOVE, above);
		write_reg(REG_OFFSET, 48'(off));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [7:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		pixel_in <= px;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_pixel(px);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// mode 0: random, 1: alternating extremes, 2: constant fill
	task automatic send_frame(int unsigned w, int unsigned h, int mode, logic [7:0] fill);
		for (int unsigned i = 0; i < w * h; i++) begin
			case (mode)
				0: send_pixel(8'($urandom));
				1: send_pixel(((i + i / w) % 2) ? 8'hFF : 8'h00);
				default: send_pixel(fill);
			endcase
		end
	endtask

	function automatic logic [47:0] rand_taps();
		return {16'($urandom), 16'($urandom), 16'($urandom)};
	endfunction

	task automatic test_identity_edges();
		set_filter(13'd4, 13'd4, 48'h0, 48'h0000_1000_0000, 48'h0, 22'h0);
		send_frame(4, 4, 1, 8'h00);
		wait_idle();
	endtask

	task automatic test_tap_extremes();
		set_filter(13'd3, 13'd3, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
			48'h7FFF_8000_7FFF, 22'h1FFFFF);
		send_frame(3, 3, 0, 8'h00);
		wait_idle();
		set_filter(13'd3, 13'd3, 48'h8000_8000_8000, 48'h8000_8000_8000,
			48'h8000_8000_8000, 22'h200000);
		send_frame(3, 3, 2, 8'hFF);
		wait_idle();
	endtask

	task automatic test_round_tie();
		set_filter(13'd3, 13'd3, 48'h0, 48'h0000_0800_0000, 48'h0, 22'h0);
		send_frame(3, 3, 2, 8'h01);
		wait_idle();
		set_filter(13'd3, 13'd3, 48'h0, 48'h0000_0800_0000, 48'h0, 22'h3FF800);
		send_frame(3, 3, 2, 8'h03);
		wait_idle();
	endtask

	task automatic test_size_clamp();
		set_filter(13'd0, 13'd1, rand_taps(), rand_taps(), rand_taps(), 22'($urandom));
		send_frame(2, 2, 0, 8'h00);
		wait_idle();
		set_filter(13'h1FFF, 13'd2, rand_taps(), rand_taps(), rand_taps(), 22'h0);
		for (int i = 0; i < 24; i++) send_pixel(8'($urandom));
		wait_idle();
		set_filter(13'd2, 13'h1FFF, rand_taps(), rand_taps(), rand_taps(), 22'h0);
		for (int i = 0; i < 48; i++) send_pixel(8'($urandom));
		wait_idle();
	endtask

	task automatic test_midframe_resize();
		set_filter(13'd8, 13'd6, rand_taps(), rand_taps(), rand_taps(), 22'h0);
		send_frame(8, 6, 0, 8'h00);
		for (int i = 0; i < 21; i++) send_pixel(8'($urandom));
		wait_idle();
		set_filter(13'd4, 13'd5, rand_taps(), rand_taps(), rand_taps(), 22'h0);
		send_frame(4, 5, 0, 8'h00);
		wait_idle();
	endtask

	task automatic test_back_pressure();
		set_filter(13'd6, 13'd4, rand_taps(), rand_taps(), rand_taps(), 22'h0);
		hold_cycles = 300;
		send_frame(6, 4, 0, 8'h00);
		wait_idle();
		send_frame(6, 4, 0, 8'h00);
		push <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		send_frame(6, 4, 0, 8'h00);
		wait_idle();
	endtask

	task automatic test_random_frames(int send_pct, int recv_pct, int unsigned budget);
		int unsigned w, h, sent;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < budget) begin
			w = $urandom_range(12, 2);
			h = $urandom_range(8, 2);
			set_filter(13'(w), 13'(h), rand_taps(), rand_taps(), rand_taps(),
				22'($urandom));
			send_frame(w, h, 0, 8'h00);
			sent += w * h;
			wait_idle();
		end
	endtask

	// Result side: one beat at each edge where pop is high and empty is low.
	initial begin
		px_result_t x;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result beat: pixel %0d row %0d col %0d",
						pixel_out, out_row, out_col);
					err_cnt++;
				end else begin
					x = expected_q.pop_front();
					if (pixel_out !== x.pix) begin
						$error("pixel_out: expected %0d, actual %0d", x.pix, pixel_out);
						err_cnt++;
					end
					if (out_row !== x.row) begin
						$error("out_row: expected %0d, actual %0d", x.row, out_row);
						err_cnt++;
					end
					if (out_col !== x.col) begin
						$error("out_col: expected %0d, actual %0d", x.col, out_col);
						err_cnt++;
					end
					if (run_end !== x.re) begin
						$error("run_end: expected %0d, actual %0d", x.re, run_end);
						err_cnt++;
					end
					if (frame_end !== x.fe) begin
						$error("frame_end: expected %0d, actual %0d", x.fe, frame_end);
						err_cnt++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = 48'h0;
		push = 1'b0;
		pixel_in = 8'h00;
		err_cnt = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		m_width = 13'd640;
		m_height = 13'd480;
		m_below = 48'h0;
		m_middle = 48'h0000_1000_0000;
		m_above = 48'h0;
		m_offset = 22'h0;
		for (int i = 0; i < 6; i++) win[i] = 8'h00;
		col_cnt = 0;
		row_cnt = 0;
		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_edges();
		test_tap_extremes();
		test_round_tie();
		test_size_clamp();
		test_midframe_resize();
		test_back_pressure();
		test_random_frames(0, 0, 40);
		test_random_frames(61, 0, 40);
		test_random_frames(0, 61, 40);
		test_random_frames(31, 31, 40);

		wait_idle();
		if (err_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/c3f_pkg.sv
rtl/core/c3f_front.sv
rtl/core/c3f_fifo.sv
rtl/core/c3f_back.sv
rtl/core/conv3x3_u8_filter.sv
rtl/core/c3f_checker.sv
tb/tb_top.sv
